FILE: rtl/pad_pkg.sv
// ----------------------------------------------------------------------------
// pad_pkg
// Types and constants shared by the polar angle and depth unit.
// ----------------------------------------------------------------------------
`default_nettype none

package pad_pkg;

	localparam int DIV_W      = 16;
	localparam int DIV_CNT_W  = $clog2(DIV_W + 1);
	localparam int FIELD_W    = 8;
	localparam int RES_W      = 5;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_DEPTH_SCALE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEPTH_LIMIT = 2'd1;

	localparam logic [DIV_W-1:0] SCALE_RESET = 16'd800;
	localparam logic [RES_W-1:0] LIMIT_RESET = 5'd31;

	localparam logic [RES_W-1:0] ANG_RIGHT = 5'd0;
	localparam logic [RES_W-1:0] ANG_DOWN  = 5'd8;
	localparam logic [RES_W-1:0] ANG_LEFT  = 5'd16;
	localparam logic [RES_W-1:0] ANG_UP    = 5'd24;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQR,
		ST_ANG,
		ST_ROOT,
		ST_DEPTH,
		ST_DONE
	} pad_state_t;

	typedef struct packed {
		logic signed [FIELD_W-1:0] horiz_offset;
		logic signed [FIELD_W-1:0] vert_offset;
	} pad_in_t;

	typedef struct packed {
		logic [RES_W-1:0] angle;
		logic [RES_W-1:0] depth;
	} pad_out_t;

endpackage

`default_nettype wire

FILE: rtl/polar_angle_depth_unit_core.sv
// ----------------------------------------------------------------------------
// polar_angle_depth_unit_core
// Maps a signed pixel offset to a 5-bit polar angle and a 5-bit depth.
//
// The input channel takes one request of two signed offsets; in_stall is high
// while a request is being worked on. The output channel presents one result
// (angle, depth) per request in a register, so a new request is taken while a
// finished result still waits on out_stall. A result that cannot be handed
// over holds the unit in its final state until the output register frees.
// Configuration writes to depth_scale and depth_limit are always taken and
// must only come while the unit is idle.
// A request passes through the squarer, the angle division, P Newton passes
// of the square root (P is one to about ten) and the depth division. The
// single shared bit-serial divider serves the angle ratio, every Newton pass
// and the depth quotient. A zero offset skips the divider and finishes after
// the squarer. A new request is taken only once the last result has been
// loaded into the output register. Reset returns the unit to idle with
// depth_scale 800 and depth_limit 31 and drops any held result.
// ----------------------------------------------------------------------------
`default_nettype none

module polar_angle_depth_unit_core import pad_pkg::*; #(
	parameter int OFFSET_BITS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  pad_in_t               in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output pad_out_t              out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int MAG_W = OFFSET_BITS;
	localparam int SQ_W  = 2 * OFFSET_BITS;

	pad_state_t        state_q;
	pad_state_t        state_d;
	logic [DIV_W-1:0]  depth_scale_q;
	logic [RES_W-1:0]  depth_limit_q;
	logic              out_valid_q;
	pad_out_t          out_data_q;

	logic [MAG_W-1:0]  x_u;
	logic [MAG_W-1:0]  y_u;
	logic              x_neg;
	logic              y_neg;
	logic [MAG_W-1:0]  ax;
	logic [MAG_W-1:0]  ay;
	logic              in_accept;

	logic              x_pos_q;
	logic              x_nneg_q;
	logic              y_pos_q;
	logic              y_nneg_q;
	logic              major_x_q;
	logic [MAG_W-1:0]  min_q;
	logic [MAG_W-1:0]  max_q;
	logic [SQ_W-1:0]   sq_q;
	logic [DIV_W-1:0]  root_q;
	logic [RES_W-1:0]  angle_q;
	logic [RES_W-1:0]  depth_q;

	logic              sqr_done;
	logic [SQ_W-1:0]   sq;
	logic              div_start;
	logic [DIV_W-1:0]  div_dvd;
	logic [DIV_W-1:0]  div_dvs;
	logic              div_done;
	logic [DIV_W-1:0]  quo;
	logic              out_load;

	logic [DIV_W-1:0]  root_half;
	logic [DIV_W-1:0]  root_init;
	logic [DIV_W:0]    root_sum;
	logic [DIV_W-1:0]  root_next;
	logic [DIV_W-1:0]  root_fin;
	logic              root_drop;
	logic [RES_W-1:0]  step;
	logic [RES_W-1:0]  angle_calc;
	logic [RES_W-1:0]  depth_calc;

	assign x_u       = in_data.horiz_offset[OFFSET_BITS-1:0];
	assign y_u       = in_data.vert_offset[OFFSET_BITS-1:0];
	assign x_neg     = x_u[MAG_W-1];
	assign y_neg     = y_u[MAG_W-1];
	assign ax        = x_neg ? (~x_u + MAG_W'(1)) : x_u;
	assign ay        = y_neg ? (~y_u + MAG_W'(1)) : y_u;
	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	pad_sqr #(
		.MAG_W (MAG_W)
	) u_sqr (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (in_accept),
		.mag_a  (ax),
		.mag_b  (ay),
		.done   (sqr_done),
		.sum_sq (sq)
	);

	pad_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.done     (div_done),
		.quotient (quo)
	);

	assign root_half = DIV_W'(sq_q >> 1);
	assign root_init = (root_half == '0) ? DIV_W'(1) : root_half;
	assign root_sum  = {1'b0, root_q} + {1'b0, quo};
	assign root_next = root_sum[DIV_W:1];
	assign root_drop = root_next < root_q;
	assign root_fin  = (root_next == '0) ? DIV_W'(1) : root_next;

	assign step = {1'b0, quo[3:0]};

	always_comb begin
		if (major_x_q) begin
			if (x_pos_q) begin
				angle_calc = y_nneg_q ? (ANG_RIGHT + step) : (ANG_RIGHT - step);
			end else begin
				angle_calc = y_nneg_q ? (ANG_LEFT - step) : (ANG_LEFT + step);
			end
		end else begin
			if (y_pos_q) begin
				angle_calc = x_nneg_q ? (ANG_DOWN - step) : (ANG_DOWN + step);
			end else begin
				angle_calc = x_nneg_q ? (ANG_UP + step) : (ANG_UP - step);
			end
		end
	end

	assign depth_calc = (quo > DIV_W'(depth_limit_q)) ? depth_limit_q : quo[RES_W-1:0];

	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		div_dvd   = DIV_W'(sq_q);
		div_dvs   = root_init;
		out_load  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_accept) begin
					state_d = ST_SQR;
				end
			end
			ST_SQR: begin
				if (sqr_done) begin
					if (sq == '0) begin
						state_d = ST_DONE;
					end else begin
						state_d   = ST_ANG;
						div_start = 1'b1;
						div_dvd   = DIV_W'({min_q, 3'b000});
						div_dvs   = DIV_W'(max_q);
					end
				end
			end
			ST_ANG: begin
				if (div_done) begin
					state_d   = ST_ROOT;
					div_start = 1'b1;
					div_dvd   = DIV_W'(sq_q);
					div_dvs   = root_init;
				end
			end
			ST_ROOT: begin
				if (div_done) begin
					div_start = 1'b1;
					if (root_drop) begin
						div_dvd = DIV_W'(sq_q);
						div_dvs = root_next;
					end else begin
						state_d = ST_DEPTH;
						div_dvd = depth_scale_q;
						div_dvs = root_fin;
					end
				end
			end
			ST_DEPTH: begin
				if (div_done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			out_valid_q   <= 1'b0;
			depth_scale_q <= SCALE_RESET;
			depth_limit_q <= LIMIT_RESET;
		end else begin
			state_q <= state_d;
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_DEPTH_SCALE: depth_scale_q <= cfg_data;
					REG_DEPTH_LIMIT: depth_limit_q <= cfg_data[RES_W-1:0];
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			x_pos_q   <= !x_neg && (x_u != '0);
			x_nneg_q  <= !x_neg;
			y_pos_q   <= !y_neg && (y_u != '0);
			y_nneg_q  <= !y_neg;
			major_x_q <= ax >= ay;
			min_q     <= (ax >= ay) ? ay : ax;
			max_q     <= (ax >= ay) ? ax : ay;
		end
		if ((state_q == ST_SQR) && sqr_done) begin
			sq_q    <= sq;
			angle_q <= ANG_RIGHT;
			depth_q <= depth_limit_q;
		end
		if ((state_q == ST_ANG) && div_done) begin
			angle_q <= angle_calc;
			root_q  <= root_init;
		end
		if ((state_q == ST_ROOT) && div_done) begin
			root_q <= root_drop ? root_next : root_fin;
		end
		if ((state_q == ST_DEPTH) && div_done) begin
			depth_q <= depth_calc;
		end
		if (out_load) begin
			out_data_q.angle <= angle_q;
			out_data_q.depth <= depth_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

`default_nettype wire

FILE: rtl/pad_sqr.sv
// ----------------------------------------------------------------------------
// pad_sqr
// Bit-serial sum of two squares, one multiplier bit of each operand per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pad_sqr import pad_pkg::*; #(
	parameter int MAG_W = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [MAG_W-1:0]     mag_a,
	input  logic [MAG_W-1:0]     mag_b,
	output logic                 done,
	output logic [2*MAG_W-1:0]   sum_sq
);

	localparam int SQ_W  = 2 * MAG_W;
	localparam int CNT_W = $clog2(MAG_W + 1);

	logic [SQ_W-1:0]  mcand_a_q;
	logic [SQ_W-1:0]  mcand_b_q;
	logic [MAG_W-1:0] mplier_a_q;
	logic [MAG_W-1:0] mplier_b_q;
	logic [SQ_W-1:0]  acc_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [SQ_W-1:0]  term_a;
	logic [SQ_W-1:0]  term_b;

	assign term_a = mplier_a_q[0] ? mcand_a_q : '0;
	assign term_b = mplier_b_q[0] ? mcand_b_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(MAG_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mcand_a_q  <= SQ_W'(mag_a);
			mcand_b_q  <= SQ_W'(mag_b);
			mplier_a_q <= mag_a;
			mplier_b_q <= mag_b;
			acc_q      <= '0;
		end else if (busy_q) begin
			acc_q      <= acc_q + term_a + term_b;
			mcand_a_q  <= mcand_a_q << 1;
			mcand_b_q  <= mcand_b_q << 1;
			mplier_a_q <= mplier_a_q >> 1;
			mplier_b_q <= mplier_b_q >> 1;
		end
	end

	assign done   = done_q;
	assign sum_sq = acc_q;

endmodule

`default_nettype wire

FILE: rtl/pad_div.sv
// ----------------------------------------------------------------------------
// pad_div
// Restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pad_div import pad_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIV_W-1:0] dividend,
	input  logic [DIV_W-1:0] divisor,
	output logic             done,
	output logic [DIV_W-1:0] quotient
);

	logic [DIV_W-1:0]     rem_q;
	logic [DIV_W-1:0]     quo_q;
	logic [DIV_W-1:0]     dvs_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DIV_W:0]       shifted;
	logic [DIV_W:0]       diff;
	logic                 fits;

	assign shifted = {rem_q, quo_q[DIV_W-1]};
	assign diff    = shifted - {1'b0, dvs_q};
	assign fits    = !diff[DIV_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == DIV_CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the polar angle and depth unit.
//
// Requests of two signed offsets are queued by the main sequence and sent by a
// clocked driver. Each accepted request is predicted at once from a shadow of
// the two configuration registers. A clocked monitor compares every accepted
// result against the oldest prediction. The run covers directed corner
// offsets, then random phases under changing register settings and
// sender/receiver idle mixes.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
	import pad_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
	localparam int PHASES = 8;
	localparam int REQS_PER_PHASE = 194;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	pad_in_t               in_data = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	pad_out_t              out_data;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	pad_in_t  offset_queue[$];
	pad_out_t polar_queue[$];
	logic [DIV_W-1:0] cur_scale;
	logic [RES_W-1:0] cur_limit;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int errors = 0;

	polar_angle_depth_unit_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic pad_out_t predict_polar(pad_in_t req);
		int x, y, ax, ay, t, a;
		int unsigned sq, root, prev, q;
		pad_out_t r;
		x = $signed(req.horiz_offset);
		y = $signed(req.vert_offset);
		ax = x < 0 ? -x : x;
		ay = y < 0 ? -y : y;
		if (x == 0 && y == 0) begin
			a = 0;
		end else if (ax >= ay) begin
			t = (ay * 8) / ax;
			if (x > 0)
				a = (y >= 0) ? t : 32 - t;
			else
				a = (y >= 0) ? 16 - t : 16 + t;
		end else begin
			t = (ax * 8) / ay;
			if (y > 0)
				a = (x >= 0) ? 8 - t : 8 + t;
			else
				a = (x >= 0) ? 24 + t : 24 - t;
		end
		r.angle = RES_W'(a & 31);
		sq = x * x + y * y;
		if (sq == 0) begin
			r.depth = cur_limit;
		end else begin
			root = sq >> 1;
			if (root == 0)
				root = 1;
			do begin
				prev = root;
				root = (prev + sq / prev) >> 1;
			end while (root < prev);
			if (root == 0)
				root = 1;
			q = cur_scale / root;
			r.depth = (q > cur_limit) ? cur_limit : RES_W'(q);
		end
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("ERROR %0t: %s", $realtime, msg);
		errors++;
	endtask

	task automatic push_offset(input int x, input int y);
		pad_in_t req;
		req.horiz_offset = FIELD_W'(x);
		req.vert_offset  = FIELD_W'(y);
		offset_queue.push_back(req);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_DEPTH_SCALE: cur_scale = val;
			REG_DEPTH_LIMIT: cur_limit = val[RES_W-1:0];
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		while (offset_queue.size() != 0 || in_valid || polar_queue.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic push_random_offset();
		int kind, m, x, y;
		kind = $urandom_range(0, 9);
		if (kind < 5) begin
			x = $urandom_range(0, 255) - 128;
			y = $urandom_range(0, 255) - 128;
		end else if (kind < 8) begin
			x = $urandom_range(0, 16) - 8;
			y = $urandom_range(0, 16) - 8;
		end else if (kind == 8) begin
			m = $urandom_range(0, 127);
			x = $urandom_range(0, 1) ? m : -m;
			y = $urandom_range(0, 2) == 0 ? 0 : ($urandom_range(0, 1) ? m : -m);
			if ($urandom_range(0, 1)) begin
				m = x;
				x = y;
				y = m;
			end
		end else begin
			m = $urandom_range(9, 127);
			x = $urandom_range(0, 1) ? m : -m;
			y = $urandom_range(0, 2) - 1;
			if ($urandom_range(0, 1)) begin
				m = x;
				x = y;
				y = m;
			end
		end
		push_offset(x, y);
	endtask

	// Request driver: a payload stays put while stalled.
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_valid && in_stall) begin
			in_valid <= 1'b1;
		end else begin
			if (in_valid)
				polar_queue.push_back(predict_polar(in_data));
			if (offset_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				in_valid <= 1'b1;
				in_data  <= offset_queue.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		pad_out_t exp_res;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (polar_queue.size() == 0) begin
					report_mismatch($sformatf("unexpected result angle %0d depth %0d",
						out_data.angle, out_data.depth));
				end else begin
					exp_res = polar_queue.pop_front();
					if (out_data.angle !== exp_res.angle)
						report_mismatch($sformatf("angle %0d, expected %0d",
							out_data.angle, exp_res.angle));
					if (out_data.depth !== exp_res.depth)
						report_mismatch($sformatf("depth %0d, expected %0d",
							out_data.depth, exp_res.depth));
				end
			end
			out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
		end
	end

	initial begin
		#20_000_000;
		$display("FAIL polar_angle_depth_unit_core");
		$finish;
	end

	initial begin
		logic [DIV_W-1:0] scales[PHASES];
		logic [RES_W-1:0] limits[PHASES];
		scales = '{16'd800, 16'd65535, 16'd1, 16'd0, 16'd12345, 16'd1, 16'd0, 16'd800};
		limits = '{5'd31, 5'd31, 5'd1, 5'd17, 5'd0, 5'd31, 5'd0, 5'd31};
		scales[6] = DIV_W'($urandom_range(1, 65535));
		limits[6] = RES_W'($urandom_range(1, 31));
		cur_scale = SCALE_RESET;
		cur_limit = LIMIT_RESET;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		push_offset(0, 0);
		push_offset(127, 0);
		push_offset(-128, 0);
		push_offset(0, 127);
		push_offset(0, -128);
		push_offset(127, 127);
		push_offset(-128, -128);
		push_offset(127, -128);
		push_offset(-128, 127);
		push_offset(1, 0);
		push_offset(0, 1);
		push_offset(-1, 0);
		push_offset(0, -1);
		push_offset(1, 1);
		push_offset(1, -1);
		push_offset(-1, -1);
		push_offset(-1, 1);
		push_offset(100, -1);
		push_offset(127, -15);
		push_offset(5, -1);
		push_offset(-5, 3);
		push_offset(3, -100);
		push_offset(-128, 1);
		wait_drained();

		for (int p = 0; p < PHASES; p++) begin
			if (p == 4) begin
				write_register(REG_SPARE_A, CFG_DATA_W'($urandom()));
				write_register(REG_SPARE_B, CFG_DATA_W'($urandom()));
			end
			write_register(REG_DEPTH_SCALE, scales[p]);
			write_register(REG_DEPTH_LIMIT,
				{CFG_DATA_W'($urandom_range(0, 2047)) << RES_W} | limits[p]);
			case (p % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
				default: begin send_idle_pct = 30; recv_stall_pct = 30; end
			endcase
			for (int i = 0; i < REQS_PER_PHASE; i++)
				push_random_offset();
			wait_drained();
			send_idle_pct = 0;
			recv_stall_pct = 0;
		end

		repeat (300) @(posedge clk);
		if (errors == 0)
			$display("PASS polar_angle_depth_unit_core");
		else
			$display("FAIL polar_angle_depth_unit_core");
		$finish;
	end

endmodule

`default_nettype wire

FILE: sim.f
rtl/pad_pkg.sv
rtl/pad_sqr.sv
rtl/pad_div.sv
rtl/polar_angle_depth_unit_core.sv
tb/sv/tb.sv
